[rtl/ffha_pkg.sv]
package ffha_pkg;

    // Default geometry of the managed heap.
    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 32;

    // Operation codes carried in the request.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [16:0] req_bytes;
        logic [15:0] payload_offset;
    } ffha_req_t;

    typedef struct packed {
        logic [15:0] alloc_offset;
        logic        ok;
        logic [15:0] free_bytes;
    } ffha_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_F_NRD,
        S_F_NCHK,
        S_F_WRD,
        S_F_WCHK,
        S_F_FIN,
        S_F_FIN2,
        S_DONE
    } ffha_state_t;

endpackage

[rtl/ffha_hdr_ram.sv]
module ffha_hdr_ram
    import ffha_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int DW    = 22,
    parameter int IW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [IW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ffha_engine.sv]
module ffha_engine
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int DEPTH        = (HEAP_BYTES + 15) / 16,
    parameter int IW           = $clog2(DEPTH),
    parameter int EW           = $clog2(HEAP_BYTES) + 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ffha_req_t     req,
    input  logic          res_ready,
    output logic          idle,
    output logic          done,
    output ffha_rsp_t     res,
    output logic          mem_we,
    output logic [IW-1:0] mem_waddr,
    output logic [EW-1:0] mem_wdata,
    output logic [IW-1:0] mem_raddr,
    input  logic [EW-1:0] mem_rdata
);

    localparam int SW  = EW - 6;
    localparam int XW  = ((SW > 17) ? SW : 17) + 3;
    localparam int FTW = SW + 1;

    localparam logic [XW-1:0]  HEAP_X  = XW'(HEAP_BYTES);
    localparam logic [XW-1:0]  HDR_X   = XW'(HEADER_BYTES);
    localparam logic [XW-1:0]  DEPTH_X = XW'(DEPTH);
    localparam logic [XW-1:0]  GMASK_X = XW'(15);
    localparam logic [XW-1:0]  GRAN_X  = XW'(16);
    localparam logic [FTW-1:0] FT_INIT = FTW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [IW-1:0]  LAST_IX = IW'(DEPTH - 1);

    function automatic logic [EW-1:0] pack_ent(input logic v, input logic f,
                                               input logic [3:0] lo,
                                               input logic [SW-1:0] sz);
        return {v, f, lo, sz};
    endfunction

    function automatic logic [IW-1:0] ix(input logic [XW-1:0] a);
        return IW'(a >> 4);
    endfunction

    ffha_state_t    state_reg, state_next;
    logic [IW-1:0]  clr_reg, clr_next;
    logic [XW-1:0]  h_reg, h_next;
    logic [XW-1:0]  h2_reg, h2_next;
    logic [XW-1:0]  c_reg, c_next;
    logic [XW-1:0]  prv_reg, prv_next;
    logic [XW-1:0]  want_reg, want_next;
    logic [SW-1:0]  e_size_reg, e_size_next;
    logic [SW-1:0]  pe_size_reg, pe_size_next;
    logic           pe_free_reg, pe_free_next;
    logic           have_reg, have_next;
    logic [FTW-1:0] ft_reg, ft_next;
    logic [15:0]    off_reg, off_next;
    logic           ok_reg, ok_next;

    logic           rd_v, rd_f;
    logic [3:0]     rd_lo;
    logic [SW-1:0]  rd_sz;
    logic [XW-1:0]  sz_x, nxt_x, pf_x, split_x;

    assign rd_sz = mem_rdata[SW-1:0];
    assign rd_lo = mem_rdata[SW+3:SW];
    assign rd_f  = mem_rdata[SW+4];
    assign rd_v  = mem_rdata[SW+5];
    assign sz_x  = XW'(rd_sz);
    assign pf_x  = XW'(req.payload_offset);
    assign split_x = h_reg + HDR_X + want_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ft_reg    <= FT_INIT;
            have_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ft_reg    <= ft_next;
            have_reg  <= have_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg       <= h_next;
        h2_reg      <= h2_next;
        c_reg       <= c_next;
        prv_reg     <= prv_next;
        want_reg    <= want_next;
        e_size_reg  <= e_size_next;
        pe_size_reg <= pe_size_next;
        pe_free_reg <= pe_free_next;
        off_reg     <= off_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        h_next       = h_reg;
        h2_next      = h2_reg;
        c_next       = c_reg;
        prv_next     = prv_reg;
        want_next    = want_reg;
        e_size_next  = e_size_reg;
        pe_size_next = pe_size_reg;
        pe_free_next = pe_free_reg;
        have_next    = have_reg;
        ft_next      = ft_reg;
        off_next     = off_reg;
        ok_next      = ok_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;
        nxt_x        = h_reg + HDR_X + sz_x;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg == '0) ? pack_ent(1'b1, 1'b1, 4'd0, FT_INIT[SW-1:0])
                                            : '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                off_next = '0;
                ok_next  = 1'b0;
                if (start)
                begin
                    if (req.op == OP_ALLOC)
                    begin
                        if (req.req_bytes == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            want_next  = (XW'(req.req_bytes) + GMASK_X) & ~GMASK_X;
                            h_next     = '0;
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        if (pf_x < HDR_X || ((pf_x - HDR_X) >> 4) >= DEPTH_X)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            h_next     = pf_x - HDR_X;
                            state_next = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD:
            begin
                mem_raddr  = ix(h_reg);
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (!(rd_v && rd_lo == h_reg[3:0]))
                begin
                    state_next = S_DONE;
                end
                else if (rd_f && sz_x >= want_reg)
                begin
                    ok_next     = 1'b1;
                    off_next    = 16'(h_reg + HDR_X);
                    e_size_next = rd_sz;
                    mem_we      = 1'b1;
                    mem_waddr   = ix(h_reg);
                    if (sz_x >= want_reg + HDR_X + GRAN_X)
                    begin
                        mem_wdata  = pack_ent(1'b1, 1'b0, rd_lo, SW'(want_reg));
                        ft_next    = ft_reg - FTW'(want_reg + HDR_X);
                        state_next = S_A_SPLIT;
                    end
                    else
                    begin
                        mem_wdata  = pack_ent(1'b1, 1'b0, rd_lo, rd_sz);
                        ft_next    = ft_reg - FTW'(sz_x);
                        state_next = S_DONE;
                    end
                end
                else if (nxt_x >= HEAP_X)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    h_next     = nxt_x;
                    state_next = S_A_RD;
                end
            end
            S_A_SPLIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ix(split_x);
                mem_wdata  = pack_ent(1'b1, 1'b1, split_x[3:0],
                                      SW'(XW'(e_size_reg) - want_reg - HDR_X));
                state_next = S_DONE;
            end
            S_F_RD:
            begin
                mem_raddr  = ix(h_reg);
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (!(rd_v && rd_lo == h_reg[3:0]))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ok_next     = 1'b1;
                    e_size_next = rd_sz;
                    if (!rd_f)
                    begin
                        ft_next = ft_reg + FTW'(sz_x);
                    end
                    c_next    = '0;
                    have_next = 1'b0;
                    if (nxt_x < HEAP_X)
                    begin
                        h2_next    = nxt_x;
                        state_next = S_F_NRD;
                    end
                    else
                    begin
                        state_next = S_F_WRD;
                    end
                end
            end
            S_F_NRD:
            begin
                mem_raddr  = ix(h2_reg);
                state_next = S_F_NCHK;
            end
            S_F_NCHK:
            begin
                if (rd_v && rd_lo == h2_reg[3:0] && rd_f)
                begin
                    e_size_next = SW'(XW'(e_size_reg) + HDR_X + sz_x);
                    mem_we      = 1'b1;
                    mem_waddr   = ix(h2_reg);
                    mem_wdata   = pack_ent(1'b0, rd_f, rd_lo, rd_sz);
                    ft_next     = ft_reg + FTW'(HDR_X);
                end
                state_next = S_F_WRD;
            end
            S_F_WRD:
            begin
                if (c_reg < h_reg)
                begin
                    mem_raddr  = ix(c_reg);
                    state_next = S_F_WCHK;
                end
                else
                begin
                    state_next = S_F_FIN;
                end
            end
            S_F_WCHK:
            begin
                if (!(rd_v && rd_lo == c_reg[3:0]))
                begin
                    state_next = S_F_FIN;
                end
                else
                begin
                    prv_next     = c_reg;
                    have_next    = 1'b1;
                    pe_size_next = rd_sz;
                    pe_free_next = rd_f;
                    c_next       = c_reg + HDR_X + sz_x;
                    state_next   = S_F_WRD;
                end
            end
            S_F_FIN:
            begin
                mem_we = 1'b1;
                if (have_reg && c_reg == h_reg && pe_free_reg)
                begin
                    mem_waddr  = ix(prv_reg);
                    mem_wdata  = pack_ent(1'b1, 1'b1, prv_reg[3:0],
                                          SW'(XW'(pe_size_reg) + HDR_X + XW'(e_size_reg)));
                    ft_next    = ft_reg + FTW'(HDR_X);
                    state_next = S_F_FIN2;
                end
                else
                begin
                    mem_waddr  = ix(h_reg);
                    mem_wdata  = pack_ent(1'b1, 1'b1, h_reg[3:0], e_size_reg);
                    state_next = S_DONE;
                end
            end
            S_F_FIN2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ix(h_reg);
                mem_wdata  = pack_ent(1'b0, 1'b1, h_reg[3:0], e_size_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res.alloc_offset = off_reg;
    assign res.ok           = ok_reg;
    assign res.free_bytes   = 16'(ft_reg);

    // The free total can never exceed one whole-heap block.
    a_ft_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ft_reg <= FT_INIT)
        else $error("free total above heap size");

    // No header write while idle or while a result waits to be taken.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !mem_we)
        else $error("header write outside of an operation");

    // A request is only started from the idle state.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> idle)
        else $error("request started while busy");

    // A finished result that is taken returns the engine to idle.
    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_ready) |=> idle)
        else $error("engine did not return to idle");

endmodule

[rtl/first_fit_heap_allocator_core.sv]
// First-fit heap allocator with block coalescing.
// The request channel (req_valid, req_stall, req) carries one allocate or free
// operation per transfer; the response channel (rsp_valid, rsp_stall, rsp)
// returns exactly one result per request, in order. Block headers live in a
// single-port-write header memory with one entry per 16-byte granule.
// Each header visited takes one memory read and one check. An allocate walks
// the headers from the start of the heap to the first free block that fits,
// and writes one more header when that block is split. A free reads the freed
// header, then the next one, which it merges when free, unless the freed block
// is the last; it then walks the blocks from the heap start up to the freed one
// and writes one more header when it merges into the previous block. A
// zero-size allocate or a free with an offset below one header or past the
// heap answers without a header read; a free that finds no valid header
// answers after its check. One request is processed at a time, and req_stall
// is high from the transfer until the result moves into the output register.
// After reset the block runs a clearing pass over the header memory, one
// entry per cycle, and holds req_stall high until it ends; the heap then
// holds one free block.
// The result sits in an output register; while rsp_stall is high it holds,
// and the engine waits with the next result until the register is free.
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  ffha_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output ffha_rsp_t rsp
);

    localparam int DEPTH = (HEAP_BYTES + 15) / 16;
    localparam int IW    = $clog2(DEPTH);
    localparam int EW    = $clog2(HEAP_BYTES) + 6;

    logic          idle, done, start, res_ready;
    ffha_rsp_t     res;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    logic          rsp_valid_reg;
    ffha_rsp_t     rsp_reg;

    // A request transfer starts the engine only when it is idle.
    assign req_stall = !idle;
    assign start     = req_valid && idle;

    // The output register can take a new result when empty or being drained.
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    ffha_engine #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .DEPTH        (DEPTH),
        .IW           (IW),
        .EW           (EW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .res_ready (res_ready),
        .idle      (idle),
        .done      (done),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ffha_hdr_ram #(
        .DEPTH (DEPTH),
        .DW    (EW),
        .IW    (IW)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Response register: loaded when the engine finishes and there is room.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
